// File: design/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
package wsd_pkg;

	localparam int LenW = 63;

	localparam logic [7:0] FinBit     = 8'h80;
	localparam logic [7:0] MaskBit    = 8'h80;
	localparam logic [7:0] OpcodeMask = 8'h0F;
	localparam logic [7:0] Len7Mask   = 8'h7F;
	localparam logic [6:0] Len16Code  = 7'd126;
	localparam logic [6:0] Len64Code  = 7'd127;
	localparam logic [2:0] KeyBytes   = 3'd4;
	localparam logic [2:0] Ext16Bytes = 3'd2;
	// eight bytes wrap a 3-bit count back to zero
	localparam logic [2:0] Ext64Bytes = 3'd0;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0]      data_byte;
		logic            payload_present;
		logic [3:0]      frame_opcode;
		logic            final_flag;
		logic [LenW-1:0] frame_length;
		logic            last_of_frame;
	} result_t;

endpackage

// File: design/wsd_parser.sv
// header parser, unmasking and frame bookkeeping, one byte per step
module wsd_parser import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	phase_t              phase_q, phase_nxt;
	logic [2:0]          hdr_cnt_q, hdr_cnt_nxt;
	logic                masked_q, masked_nxt;
	logic [3:0]          opcode_q, opcode_nxt;
	logic                fin_q, fin_nxt;
	logic [LenW-1:0]     len_q, len_nxt;
	logic [31:0]         key_q, key_nxt;
	logic [LenW-1:0]     cnt_q, cnt_nxt;
	logic                ext_long_q, ext_long_nxt;

	logic [6:0]          len7;
	logic [2:0]          cnt_inc;
	logic [LenW-1:0]     pay_inc;
	logic [7:0]          key_byte;
	logic                pay_last;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			hdr_cnt_q  <= '0;
			masked_q   <= 1'b0;
			opcode_q   <= '0;
			fin_q      <= 1'b0;
			len_q      <= '0;
			key_q      <= '0;
			cnt_q      <= '0;
			ext_long_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_nxt;
			hdr_cnt_q  <= hdr_cnt_nxt;
			masked_q   <= masked_nxt;
			opcode_q   <= opcode_nxt;
			fin_q      <= fin_nxt;
			len_q      <= len_nxt;
			key_q      <= key_nxt;
			cnt_q      <= cnt_nxt;
			ext_long_q <= ext_long_nxt;
		end
	end

	// helper values for the current byte
	assign len7     = 7'(rx_byte & Len7Mask);
	assign cnt_inc  = hdr_cnt_q + 3'd1;
	assign pay_inc  = cnt_q + LenW'(1);
	assign pay_last = (pay_inc >= len_q);

	// key byte selected by payload index mod 4, key byte 0 in the top bits
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result
	always_comb begin
		phase_nxt    = phase_q;
		hdr_cnt_nxt  = hdr_cnt_q;
		masked_nxt   = masked_q;
		opcode_nxt   = opcode_q;
		fin_nxt      = fin_q;
		len_nxt      = len_q;
		key_nxt      = key_q;
		cnt_nxt      = cnt_q;
		ext_long_nxt = ext_long_q;
		res_valid    = 1'b0;
		res.data_byte       = 8'd0;
		res.payload_present = 1'b0;
		res.last_of_frame   = 1'b0;

		case (phase_q)
			PH_HDR1: begin
				masked_nxt  = |(rx_byte & MaskBit);
				key_nxt     = '0;
				hdr_cnt_nxt = '0;
				cnt_nxt     = '0;
				if (len7 == Len16Code) begin
					len_nxt      = '0;
					ext_long_nxt = 1'b0;
					phase_nxt    = PH_EXTLEN;
				end else if (len7 == Len64Code) begin
					len_nxt      = '0;
					ext_long_nxt = 1'b1;
					phase_nxt    = PH_EXTLEN;
				end else begin
					len_nxt = LenW'(len7);
					if (masked_nxt) begin
						phase_nxt = PH_KEY;
					end else if (len7 == 7'd0) begin
						// empty frame marker
						phase_nxt         = PH_HDR0;
						res_valid         = 1'b1;
						res.last_of_frame = 1'b1;
					end else begin
						phase_nxt = PH_PAYLOAD;
					end
				end
			end
			PH_EXTLEN: begin
				len_nxt     = {len_q[LenW-9:0], rx_byte};
				hdr_cnt_nxt = cnt_inc;
				if (cnt_inc == (ext_long_q ? Ext64Bytes : Ext16Bytes)) begin
					hdr_cnt_nxt = '0;
					cnt_nxt     = '0;
					if (masked_q) begin
						phase_nxt = PH_KEY;
					end else if (len_nxt == '0) begin
						phase_nxt         = PH_HDR0;
						res_valid         = 1'b1;
						res.last_of_frame = 1'b1;
					end else begin
						phase_nxt = PH_PAYLOAD;
					end
				end
			end
			PH_KEY: begin
				key_nxt     = {key_q[23:0], rx_byte};
				hdr_cnt_nxt = cnt_inc;
				if (cnt_inc >= KeyBytes) begin
					hdr_cnt_nxt = '0;
					cnt_nxt     = '0;
					if (len_q == '0) begin
						phase_nxt         = PH_HDR0;
						res_valid         = 1'b1;
						res.last_of_frame = 1'b1;
					end else begin
						phase_nxt = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				cnt_nxt             = pay_inc;
				res_valid           = 1'b1;
				res.payload_present = 1'b1;
				res.data_byte       = masked_q ? (rx_byte ^ key_byte) : rx_byte;
				res.last_of_frame   = pay_last;
				if (pay_last) begin
					phase_nxt = PH_HDR0;
				end
			end
			default: begin
				// first header byte, also taken for unused phase codes
				fin_nxt    = |(rx_byte & FinBit);
				opcode_nxt = 4'(rx_byte & OpcodeMask);
				phase_nxt  = PH_HDR1;
			end
		endcase

		res.frame_opcode = opcode_q;
		res.final_flag   = fin_q;
		res.frame_length = len_nxt;
	end

endmodule

// File: design/wsd_out_reg.sv
// result register on the output channel
module wsd_out_reg import wsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    res_valid,
	input  result_t res,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	// free when empty or when the held result leaves this cycle
	assign can_load  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= res_valid;
		end else if (valid_q && !out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// File: design/websocket_frame_deframer_core.sv
// top level of the websocket frame deframer
//
// Takes a received websocket frame stream one byte per request on the input
// channel (in_valid, in_stall, rx_byte). Header bytes (FIN/opcode, mask and
// 7-bit length, 16- or 64-bit extended length, 4-byte masking key) produce no
// result. Each payload byte yields one result on the output channel (out_valid,
// out_stall) carrying the unmasked byte, opcode, FIN, the frame length and a
// last-of-frame mark; a zero-length frame yields one marker result with
// payload_present low on the byte that completes its header.
// A byte accepted on the input channel sits in the input register, and its
// result is loaded into the output register when the parse step runs, which
// raises out_valid. Throughput is one byte per cycle while the receiver does
// not stall, set by the single parse step between the input and output
// registers. When the receiver stalls, the held result stays put; one more
// byte can still be taken into the input register, after which in_stall
// rises until the output register frees up. Reset clears both valid flags
// and returns the parser to waiting for the first header byte of a frame.
module websocket_frame_deframer_core import wsd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      rx_byte,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      data_byte,
	output logic            payload_present,
	output logic [3:0]      frame_opcode,
	output logic            final_flag,
	output logic [LenW-1:0] frame_length,
	output logic            last_of_frame
);

	logic       rx_valid_s1;
	logic [7:0] rx_byte_s1;
	logic       can_load;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	// parse step runs when a byte waits and the result register is free
	assign step     = rx_valid_s1 && can_load;
	assign in_stall = rx_valid_s1 && !can_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			rx_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (rx_byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// result fields
	assign data_byte       = out_res.data_byte;
	assign payload_present = out_res.payload_present;
	assign frame_opcode    = out_res.frame_opcode;
	assign final_flag      = out_res.final_flag;
	assign frame_length    = out_res.frame_length;
	assign last_of_frame   = out_res.last_of_frame;

endmodule
